@@ hdl/bpa_pkg.sv @@
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared constants, types and helpers of the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int MAX_ORDER  = 7;
  localparam int NUM_LEVELS = MAX_ORDER + 1;
  localparam int ORDER_W    = 3;
  localparam int REQ_W      = 8;
  localparam int PAGE_W     = 7;
  localparam int IDX_W      = $clog2(NUM_LEVELS);
  // must hold the rounded order of the widest request and one past the top level
  localparam int LVL_W      = $clog2(((MAX_ORDER > REQ_W) ? MAX_ORDER : REQ_W) + 2);

  localparam logic [ORDER_W-1:0] POOL_ORDER_RESET = ORDER_W'(7);

  typedef logic [LVL_W-1:0]  lvl_t;
  typedef logic [PAGE_W-1:0] page_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SPLIT,
    ST_GRANT,
    ST_FAIL
  } state_t;

  typedef struct packed {
    logic accept;
    logic search_step;
    logic take;
    logic split_step;
    logic load_ok;
    logic load_fail;
  } cmd_t;

  typedef struct packed {
    logic lvl_over_top;
    logic lvl_free;
    logic lvl_above_k;
    logic out_free;
  } status_t;

  // smallest k with 2^k >= n, zero pages treated as one
  function automatic lvl_t round_up_order(input logic [REQ_W-1:0] n);
    logic [REQ_W-1:0] m;
    lvl_t             k;
    m = n - REQ_W'(1);
    k = '0;
    if (n > REQ_W'(1)) begin
      for (int i = 0; i < REQ_W; i++) begin
        if (m[i]) begin
          k = lvl_t'(i + 1);
        end
      end
    end
    return k;
  endfunction

  // pool order saturated to the largest supported level
  function automatic lvl_t effective_order(input logic [ORDER_W-1:0] po);
    lvl_t p;
    p = lvl_t'(po);
    return (p > lvl_t'(MAX_ORDER)) ? lvl_t'(MAX_ORDER) : p;
  endfunction

endpackage

@@ hdl/bpa_ctrl.sv @@
// ----------------------------------------------------------------------------
// bpa_ctrl
// Controller: sequences level search, block split and result hand-off.
// ----------------------------------------------------------------------------
module bpa_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  bpa_pkg::status_t status,
  output bpa_pkg::cmd_t    cmd
);

  bpa_pkg::state_t state;
  bpa_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bpa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bpa_pkg::ST_IDLE: begin
        if (in_valid) state_next = bpa_pkg::ST_SEARCH;
      end
      bpa_pkg::ST_SEARCH: begin
        if (status.lvl_over_top) begin
          state_next = bpa_pkg::ST_FAIL;
        end else if (status.lvl_free) begin
          state_next = bpa_pkg::ST_SPLIT;
        end
      end
      bpa_pkg::ST_SPLIT: begin
        if (!status.lvl_above_k) state_next = bpa_pkg::ST_GRANT;
      end
      bpa_pkg::ST_GRANT: begin
        if (status.out_free) state_next = bpa_pkg::ST_IDLE;
      end
      bpa_pkg::ST_FAIL: begin
        if (status.out_free) state_next = bpa_pkg::ST_IDLE;
      end
      default: state_next = bpa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      bpa_pkg::ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      bpa_pkg::ST_SEARCH: begin
        if (!status.lvl_over_top) begin
          cmd.take        = status.lvl_free;
          cmd.search_step = !status.lvl_free;
        end
      end
      bpa_pkg::ST_SPLIT: begin
        cmd.split_step = status.lvl_above_k;
      end
      bpa_pkg::ST_GRANT: begin
        cmd.load_ok = status.out_free;
      end
      bpa_pkg::ST_FAIL: begin
        cmd.load_fail = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ hdl/bpa_datapath.sv @@
// ----------------------------------------------------------------------------
// bpa_datapath
// Level table, search and split counter, and the result register.
// ----------------------------------------------------------------------------
module bpa_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wen,
  input  logic [bpa_pkg::ORDER_W-1:0]       cfg_wdata,
  input  logic [bpa_pkg::REQ_W-1:0]         request_pages,
  input  bpa_pkg::cmd_t                     cmd,
  output bpa_pkg::status_t                  status,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              alloc_failed,
  output logic [bpa_pkg::PAGE_W-1:0]        first_page,
  output logic [bpa_pkg::PAGE_W-1:0]        last_page
);

  logic [bpa_pkg::ORDER_W-1:0] pool_order;
  logic                        level_free  [bpa_pkg::NUM_LEVELS];
  bpa_pkg::page_t              level_start [bpa_pkg::NUM_LEVELS];

  bpa_pkg::lvl_t  k;
  bpa_pkg::lvl_t  lvl;
  bpa_pkg::page_t start;

  bpa_pkg::lvl_t              top;
  bpa_pkg::lvl_t              cfg_top;
  bpa_pkg::lvl_t              lvl_dn;
  logic [bpa_pkg::IDX_W-1:0]  idx;
  logic [bpa_pkg::IDX_W-1:0]  idx_dn;

  assign top     = bpa_pkg::effective_order(pool_order);
  assign cfg_top = bpa_pkg::effective_order(cfg_wdata);
  assign lvl_dn  = lvl - bpa_pkg::lvl_t'(1);
  assign idx     = lvl[bpa_pkg::IDX_W-1:0];
  assign idx_dn  = lvl_dn[bpa_pkg::IDX_W-1:0];

  // the table read is used only while lvl is at or below the top level
  assign status.lvl_over_top = lvl > top;
  assign status.lvl_free     = level_free[idx];
  assign status.lvl_above_k  = lvl > k;
  assign status.out_free     = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_order <= bpa_pkg::POOL_ORDER_RESET;
      for (int i = 0; i < bpa_pkg::NUM_LEVELS; i++) begin
        level_free[i]  <= (bpa_pkg::lvl_t'(i) ==
                           bpa_pkg::effective_order(bpa_pkg::POOL_ORDER_RESET));
        level_start[i] <= '0;
      end
    end else if (cfg_wen) begin
      pool_order <= cfg_wdata;
      for (int i = 0; i < bpa_pkg::NUM_LEVELS; i++) begin
        level_free[i]  <= (bpa_pkg::lvl_t'(i) == cfg_top);
        level_start[i] <= '0;
      end
    end else if (cmd.take) begin
      level_free[idx] <= 1'b0;
    end else if (cmd.split_step) begin
      // upper half of the block stays free one level down
      level_free[idx_dn]  <= 1'b1;
      level_start[idx_dn] <= start + (bpa_pkg::page_t'(1) << lvl_dn);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      k   <= bpa_pkg::round_up_order(request_pages);
      lvl <= bpa_pkg::round_up_order(request_pages);
    end else if (cmd.search_step) begin
      lvl <= lvl + bpa_pkg::lvl_t'(1);
    end else if (cmd.split_step) begin
      lvl <= lvl_dn;
    end
    if (cmd.take) begin
      start <= level_start[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_ok || cmd.load_fail) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_ok) begin
      alloc_failed <= 1'b0;
      first_page   <= start;
      last_page    <= start + (bpa_pkg::page_t'(1) << k) - bpa_pkg::page_t'(1);
    end else if (cmd.load_fail) begin
      alloc_failed <= 1'b1;
      first_page   <= '0;
      last_page    <= '0;
    end
  end

  a_split_above_k: assert property (@(posedge clk) disable iff (rst)
    cmd.split_step |-> (lvl > k && lvl <= top))
    else $error("split below requested order");

  a_take_free: assert property (@(posedge clk) disable iff (rst)
    cmd.take |-> (lvl <= top && lvl >= k && level_free[idx]))
    else $error("took a level that holds no free block");

  a_grant_word: assert property (@(posedge clk) disable iff (rst)
    cmd.load_ok |=> (out_valid && !alloc_failed && first_page == $past(start)))
    else $error("granted word not loaded");

  a_fail_word: assert property (@(posedge clk) disable iff (rst)
    cmd.load_fail |=> (out_valid && alloc_failed && first_page == '0 && last_page == '0))
    else $error("fail word not zeroed");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_ok || cmd.load_fail) |-> (!out_valid || !out_stall))
    else $error("result register overwritten while stalled");

endmodule

@@ hdl/buddy_page_allocator.sv @@
// ----------------------------------------------------------------------------
// buddy_page_allocator
// Allocation-only buddy page allocator: controller plus level datapath.
// ----------------------------------------------------------------------------
// sequence: after the accepting edge the search steps up a level at a time from the
//   rounded order to the first free level, then splits down a level at a time to the
//   rounded order and loads the result, or a fail word past the top level; out_stall
//   can hold the load. One request at a time: the next word is taken in the cycle
//   after the result is loaded
// reset: pool order 7, one free block at page 0, no result pending
// ----------------------------------------------------------------------------
module buddy_page_allocator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wen,
  input  logic [bpa_pkg::ORDER_W-1:0] cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [bpa_pkg::REQ_W-1:0]   request_pages,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        alloc_failed,
  output logic [bpa_pkg::PAGE_W-1:0]  first_page,
  output logic [bpa_pkg::PAGE_W-1:0]  last_page
);

  bpa_pkg::cmd_t    cmd;
  bpa_pkg::status_t status;

  bpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  bpa_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .request_pages (request_pages),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .alloc_failed  (alloc_failed),
    .first_page    (first_page),
    .last_page     (last_page)
  );

endmodule
